### design/s23x_pkg.sv
// Package: widths, codes and shared types of the Scale2x/Scale3x upscaler.
`timescale 1ns / 1ps
package s23x_pkg;
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int PIXEL_BITS = 32;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int DIM_BITS   = 10;
   localparam int ROW_BITS   = DIM_BITS + 1;
   localparam int OUT_BITS   = 11;
   localparam int QDEPTH     = 4;
   localparam int QPTR_BITS  = $clog2(QDEPTH);

   localparam logic [1:0] CSR_SCALE  = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   typedef logic [PIXEL_BITS-1:0] pix_type;

   // one classified centre: its nine neighbours and where it lands
   typedef struct packed {
      pix_type [8:0]       win;
      logic [DIM_BITS-1:0] col;
      logic [DIM_BITS-1:0] row;
      logic                frame_end;
   } job_type;
endpackage

### design/s23x_if.sv
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps
interface s23x_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/scale2x_scale3x_upscaler_core.sv
// Top level of the Scale2x/Scale3x streaming upscaler.
`timescale 1ns / 1ps
// Pixels enter in raster order; each centre yields a 2x2 (Scale2x) or 3x3 (Scale3x)
// block, one output pixel per cycle while rsp_ready is high, a rate set by the
// single-pixel output stage. After a frame send image_width+1 drain items. A write
// to the scale, width or height register restarts the frame.
module scale2x_scale3x_upscaler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_pixel,
   output logic [10:0] rsp_out_column,
   output logic [10:0] rsp_out_row,
   output logic        rsp_block_last,
   output logic        rsp_frame_last
);
   localparam int DB = s23x_pkg::DIM_BITS;
   typedef struct packed {
      logic [31:0] pixel;
      logic [10:0] column;
      logic [10:0] row;
      logic        block_last;
      logic        frame_last;
   } rsp_type;

   logic [1:0]    scale_ff;
   logic [DB-1:0] width_ff, height_ff, width_eff, height_eff;
   logic          job_valid, job_room, restart;
   s23x_pkg::job_type job;
   s23x_if #(.payload_type(rsp_type)) rsp_ch ();

   assign restart = csr_write_enable && (csr_index inside {s23x_pkg::CSR_SCALE,
      s23x_pkg::CSR_WIDTH, s23x_pkg::CSR_HEIGHT});

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 2'd2;
         width_ff <= DB'(1);
         height_ff <= DB'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            s23x_pkg::CSR_SCALE:  scale_ff <= csr_write_data[1:0];
            s23x_pkg::CSR_WIDTH:  width_ff <= csr_write_data;
            s23x_pkg::CSR_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign width_eff = (width_ff == '0) ? DB'(1) :
      (width_ff > DB'(s23x_pkg::MAX_WIDTH)) ? DB'(s23x_pkg::MAX_WIDTH) : width_ff;
   assign height_eff = (height_ff == '0) ? DB'(1) :
      (height_ff > DB'(s23x_pkg::MAX_HEIGHT)) ? DB'(s23x_pkg::MAX_HEIGHT) : height_ff;

   s23x_front u_front (
      .clock(clock), .reset(reset), .restart(restart),
      .width_eff(width_eff), .height_eff(height_eff),
      .in_valid(req_valid), .in_ready(req_ready), .in_mode(req_mode),
      .in_pixel(req_pixel), .job_valid(job_valid), .job(job), .job_room(job_room));

   s23x_back u_back (
      .clock(clock), .reset(reset), .scale3(scale_ff == 2'd3),
      .job_valid(job_valid), .job(job), .job_room(job_room), .rsp(rsp_ch.source));

   assign rsp_valid = rsp_ch.valid;
   assign rsp_ch.ready = rsp_ready;
   assign rsp_out_pixel = rsp_ch.data.pixel;
   assign rsp_out_column = rsp_ch.data.column;
   assign rsp_out_row = rsp_ch.data.row;
   assign rsp_block_last = rsp_ch.data.block_last;
   assign rsp_frame_last = rsp_ch.data.frame_last;
endmodule

### design/s23x_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module s23x_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

### design/s23x_front.sv
// Front end: line stores, 3x3 window and centre classification.
`timescale 1ns / 1ps
module s23x_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         restart,
   input  logic [s23x_pkg::DIM_BITS-1:0] width_eff,
   input  logic [s23x_pkg::DIM_BITS-1:0] height_eff,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_mode,
   input  s23x_pkg::pix_type            in_pixel,
   output logic                         job_valid,
   output s23x_pkg::job_type            job,
   input  logic                         job_room
);
   localparam int CB = s23x_pkg::COL_BITS;
   localparam int DB = s23x_pkg::DIM_BITS;
   localparam int RB = s23x_pkg::ROW_BITS;

   logic [DB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic          sel_ff, sel_in;
   logic          s1_ff, s1_in;
   logic          s1_sel_ff;
   logic [DB-1:0] s1_col_ff;
   logic [RB-1:0] s1_row_ff;
   s23x_pkg::pix_type s1_val_ff;
   s23x_pkg::pix_type [8:0] win_ff, win_in;
   logic          jv_ff, jv_in;
   s23x_pkg::job_type job_ff, job_in;

   logic [RB-1:0] h1;
   logic          wr_ok, take;
   s23x_pkg::pix_type val, q0, q1, above_q, cur_q, top, mid, bot;

   assign h1 = {1'b0, height_eff} + RB'(1);
   // the read for this item lands next cycle; hold off once the queue holds two or more jobs, and during a restart
   assign in_ready = job_room && !restart;
   assign take = in_valid && in_ready;
   assign wr_ok = row_ff < {1'b0, height_eff};
   assign val = (!in_mode && wr_ok) ? in_pixel : '0;

   // two banks swap roles after each stored row; sel_ff marks the current-row bank
   s23x_ram #(.WIDTH(s23x_pkg::PIXEL_BITS), .DEPTH(s23x_pkg::MAX_WIDTH)) u_bank0 (
      .clock(clock), .we(take && wr_ok && sel_ff), .addr(col_ff[CB-1:0]),
      .wdata(val), .rdata(q0));
   s23x_ram #(.WIDTH(s23x_pkg::PIXEL_BITS), .DEPTH(s23x_pkg::MAX_WIDTH)) u_bank1 (
      .clock(clock), .we(take && wr_ok && !sel_ff), .addr(col_ff[CB-1:0]),
      .wdata(val), .rdata(q1));

   assign cur_q = s1_sel_ff ? q1 : q0;
   assign above_q = s1_sel_ff ? q0 : q1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sel_in = sel_ff;
      if (take) begin
         if (col_ff == '0 && row_ff == h1) begin
            row_in = '0;
         end else if (col_ff + DB'(1) >= width_eff) begin
            col_in = '0;
            row_in = row_ff + RB'(1);
            if (wr_ok) sel_in = !sel_ff;
         end else begin
            col_in = col_ff + DB'(1);
         end
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_comb begin
      top = above_q;
      mid = cur_q;
      bot = s1_val_ff;
      if (s1_row_ff == RB'(1)) top = mid;
      if (s1_row_ff == {1'b0, height_eff}) bot = mid;
      win_in = win_ff;
      jv_in = 1'b0;
      job_in = job_ff;
      if (s1_ff) begin
         if (s1_col_ff != '0) begin
            win_in = {bot, mid, top, win_ff[8:3]};
            if (s1_row_ff != '0) begin
               jv_in = 1'b1;
               job_in.win = win_in;
               job_in.col = s1_col_ff - DB'(1);
               job_in.row = DB'(s1_row_ff - RB'(1));
               job_in.frame_end = 1'b0;
            end
         end else begin
            if (s1_row_ff >= RB'(2)) begin
               jv_in = 1'b1;
               job_in.win = {win_ff[8:6], win_ff[8:3]};
               job_in.col = width_eff - DB'(1);
               job_in.row = DB'(s1_row_ff - RB'(2));
               job_in.frame_end = (s1_row_ff == h1);
            end
            win_in = {bot, mid, top, bot, mid, top, win_ff[2:0]};
         end
      end
   end

   assign s1_in = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sel_ff <= 1'b0;
         s1_ff <= 1'b0;
         jv_ff <= 1'b0;
         win_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sel_ff <= sel_in;
         s1_ff <= s1_in;
         jv_ff <= jv_in;
         win_ff <= win_in;
      end
      s1_sel_ff <= sel_ff;
      s1_col_ff <= col_ff;
      s1_row_ff <= row_ff;
      s1_val_ff <= val;
      job_ff <= job_in;
   end

   assign job_valid = jv_ff;
   assign job = job_ff;
endmodule

### design/s23x_back.sv
// Back end: job queue and Scale2x/Scale3x block expansion, one pixel a cycle while the output is not stalled.
`timescale 1ns / 1ps
module s23x_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              scale3,
   input  logic              job_valid,
   input  s23x_pkg::job_type job,
   output logic              job_room,
   s23x_if.source            rsp
);
   localparam int QB = s23x_pkg::QPTR_BITS;
   localparam int OB = s23x_pkg::OUT_BITS;
   typedef struct packed {
      s23x_pkg::pix_type   pixel;
      logic [OB-1:0]       column;
      logic [OB-1:0]       row;
      logic                block_last;
      logic                frame_last;
   } out_type;

   s23x_pkg::job_type q_ff [s23x_pkg::QDEPTH];
   logic [QB-1:0] wp_ff, rp_ff;
   logic [QB:0]   cnt_ff, cnt_in;
   logic [3:0]    idx_ff, idx_in;
   logic [1:0]    dx_ff, dy_ff, dx_in, dy_in;
   logic          ov_ff, ov_in;
   out_type       o_ff, o_in;
   s23x_pkg::job_type cur;
   s23x_pkg::pix_type a, b, c, d, e, f, g, h, i, px;
   logic act, pop, adv;
   logic [3:0] last_idx;
   logic [OB-1:0] n;

   assign cur = q_ff[rp_ff];
   assign {i, f, c, h, e, b, g, d, a} = cur.win;
   assign act = (b != h) && (d != f);
   assign last_idx = scale3 ? 4'd8 : 4'd3;
   assign n = scale3 ? OB'(3) : OB'(2);
   // two slots kept spare for the items already in the front pipeline
   assign job_room = cnt_ff <= (QB+1)'(s23x_pkg::QDEPTH - 3);
   assign adv = !ov_ff || rsp.ready;
   assign pop = adv && (cnt_ff != '0) && (idx_ff == last_idx);

   always_comb begin
      px = e;
      if (act) begin
         if (!scale3) begin
            case (idx_ff[1:0])
               2'd0: px = (d == b) ? d : e;
               2'd1: px = (b == f) ? f : e;
               2'd2: px = (d == h) ? d : e;
               default: px = (h == f) ? f : e;
            endcase
         end else begin
            case (idx_ff)
               4'd0: px = (d == b) ? d : e;
               4'd1: px = ((d == b && e != c) || (b == f && e != a)) ? b : e;
               4'd2: px = (b == f) ? f : e;
               4'd3: px = ((d == b && e != g) || (d == h && e != a)) ? d : e;
               4'd5: px = ((b == f && e != i) || (h == f && e != c)) ? f : e;
               4'd6: px = (d == h) ? d : e;
               4'd7: px = ((d == h && e != i) || (h == f && e != g)) ? h : e;
               4'd8: px = (h == f) ? f : e;
               default: px = e;
            endcase
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      ov_in = ov_ff && !rsp.ready;
      o_in = o_ff;
      if (adv && cnt_ff != '0) begin
         ov_in = 1'b1;
         o_in.pixel = px;
         o_in.column = n * OB'(cur.col) + OB'(dx_ff);
         o_in.row = n * OB'(cur.row) + OB'(dy_ff);
         o_in.block_last = (idx_ff == last_idx);
         o_in.frame_last = (idx_ff == last_idx) && cur.frame_end;
         if (idx_ff == last_idx) begin
            idx_in = '0;
            dx_in = '0;
            dy_in = '0;
         end else begin
            idx_in = idx_ff + 4'd1;
            if (OB'(dx_ff) == n - OB'(1)) begin
               dx_in = '0;
               dy_in = dy_ff + 2'd1;
            end else begin
               dx_in = dx_ff + 2'd1;
            end
         end
      end
      cnt_in = cnt_ff + (QB+1)'(job_valid) - (QB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         if (job_valid) wp_ff <= wp_ff + QB'(1);
         if (pop) rp_ff <= rp_ff + QB'(1);
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         ov_ff <= ov_in;
      end
      if (job_valid) q_ff[wp_ff] <= job;
      o_ff <= o_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.data = o_ff;

   property p_no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= (QB+1)'(s23x_pkg::QDEPTH);
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("job queue overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp.ready |=> ov_ff && $stable(o_ff)) else $error("result lost");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
endmodule

### bench/scale2x_scale3x_upscaler_core_tb.sv
// Testbench: Scale2x/Scale3x upscaler against a behavioral predictor, under random flow control.
`timescale 1ns / 1ps
module scale2x_scale3x_upscaler_core_tb;
   localparam bit         MODE_PIXEL = 1'b0;
   localparam bit         MODE_DRAIN = 1'b1;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic        mode;
      logic [31:0] pixel;
   } req_type;

   typedef struct packed {
      logic [31:0] out_pixel;
      logic [10:0] out_column;
      logic [10:0] out_row;
      logic        block_last;
      logic        frame_last;
   } rsp_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   sel;     // register index or mode
      logic [31:0]  value;
      logic         typed;   // expected pixel of every result typed in
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [9:0] csr_write_data = '0;

   s23x_if #(.payload_type(req_type)) req_ch ();
   s23x_if #(.payload_type(rsp_type)) rsp_ch ();

   always #4 clock = ~clock;

   scale2x_scale3x_upscaler_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_mode         (req_ch.data.mode),
      .req_pixel        (req_ch.data.pixel),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_pixel    (rsp_ch.data.out_pixel),
      .rsp_out_column   (rsp_ch.data.out_column),
      .rsp_out_row      (rsp_ch.data.out_row),
      .rsp_block_last   (rsp_ch.data.block_last),
      .rsp_frame_last   (rsp_ch.data.frame_last)
   );

   // predictor state
   logic [31:0] above_line [s23x_pkg::MAX_WIDTH];
   logic [31:0] current_line [s23x_pkg::MAX_WIDTH];
   logic [31:0] win [9];   // index 3*col + row
   int unsigned in_x, in_y;
   logic [1:0]  scale_reg;
   logic [9:0]  width_reg, height_reg;

   rsp_type     pending_blocks [$];
   int          errors = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycles = 0;
   int unsigned random_items = 0;

   function automatic int unsigned clamp_dim(logic [9:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   task automatic emit_block(int unsigned col, int unsigned row, bit frame_end,
                             bit typed, logic [31:0] typed_pixel);
      logic [31:0] a, b, c, d, e, f, g, h, i;
      logic [31:0] blk [9];
      int unsigned n, cnt;
      rsp_type r;
      a = win[0]; b = win[3]; c = win[6];
      d = win[1]; e = win[4]; f = win[7];
      g = win[2]; h = win[5]; i = win[8];
      n = (scale_reg == 2'd3) ? 3 : 2;
      cnt = n * n;
      for (int k = 0; k < 9; k++) blk[k] = e;
      if (b != h && d != f) begin
         if (n == 2) begin
            blk[0] = (d == b) ? d : e;
            blk[1] = (b == f) ? f : e;
            blk[2] = (d == h) ? d : e;
            blk[3] = (h == f) ? f : e;
         end else begin
            blk[0] = (d == b) ? d : e;
            blk[1] = ((d == b && e != c) || (b == f && e != a)) ? b : e;
            blk[2] = (b == f) ? f : e;
            blk[3] = ((d == b && e != g) || (d == h && e != a)) ? d : e;
            blk[5] = ((b == f && e != i) || (h == f && e != c)) ? f : e;
            blk[6] = (d == h) ? d : e;
            blk[7] = ((d == h && e != i) || (h == f && e != g)) ? h : e;
            blk[8] = (h == f) ? f : e;
         end
      end
      for (int k = 0; k < cnt; k++) begin
         r.out_pixel  = typed ? typed_pixel : blk[k];
         r.out_column = 11'(n * col + k % n);
         r.out_row    = 11'(n * row + k / n);
         r.block_last = (k == cnt - 1);
         r.frame_last = (k == cnt - 1) && frame_end;
         pending_blocks.push_back(r);
      end
   endtask

   task automatic predict_item(logic mode, logic [31:0] pix, bit typed, logic [31:0] tpix);
      int unsigned w, h, x, y;
      logic [31:0] v, t, m, b;
      w = clamp_dim(width_reg, s23x_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, s23x_pkg::MAX_HEIGHT);
      x = (in_x >= w) ? w - 1 : in_x;
      y = (in_y > h + 1) ? h + 1 : in_y;
      v = (mode == MODE_PIXEL && y < h) ? pix : 32'd0;
      t = above_line[x];
      m = current_line[x];
      b = v;
      if (y == 1) t = m;
      if (y == h) b = m;
      if (y < h) begin
         above_line[x] = current_line[x];
         current_line[x] = v;
      end
      if (x >= 1) begin
         for (int k = 0; k < 6; k++) win[k] = win[k+3];
         win[6] = t; win[7] = m; win[8] = b;
         if (y >= 1) emit_block(x - 1, y - 1, 1'b0, typed, tpix);
      end else begin
         if (y >= 2) begin
            for (int k = 0; k < 6; k++) win[k] = win[k+3];
            emit_block(w - 1, y - 2, y == h + 1, typed, tpix);
         end
         win[3] = t; win[4] = m; win[5] = b;
         win[6] = t; win[7] = m; win[8] = b;
      end
      if (x == 0 && y == h + 1) begin
         in_x = 0;
         in_y = 0;
      end else begin
         x++;
         if (x >= w) begin
            x = 0;
            y++;
         end
         in_x = x;
         in_y = y;
      end
   endtask

   // waits until idle, then writes one register at a falling edge
   task automatic write_csr(logic [1:0] idx, logic [9:0] data);
      wait (pending_blocks.size() == 0);
      repeat (30) @(posedge clock);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         s23x_pkg::CSR_SCALE:  scale_reg = data[1:0];
         s23x_pkg::CSR_WIDTH:  width_reg = data;
         s23x_pkg::CSR_HEIGHT: height_reg = data;
         default: ;
      endcase
      if (idx != CSR_UNUSED) begin
         in_x = 0;
         in_y = 0;
      end
   endtask

   // valid stays high across back-to-back transfers; entered just after a falling edge
   task automatic send_item(logic mode, logic [31:0] pix, bit typed, logic [31:0] tpix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data = '{mode: mode, pixel: pix};
      do @(posedge clock); while (!req_ch.ready);
      predict_item(mode, pix, typed, tpix);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_ch.valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_pixel();
      logic [31:0] palette [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
      if ($urandom_range(3) == 0) return $urandom();
      return palette[$urandom_range(3)];
   endfunction

   task automatic random_frame();
      int unsigned w, h, total, cut;
      logic [9:0] wv, hv;
      case ($urandom_range(19))
         0: begin wv = 10'd1023; hv = 10'd1; end
         1: begin wv = 10'd1;    hv = 10'd512; end
         2: begin wv = 10'd0;    hv = 10'd0; end
         default: begin
            wv = 10'($urandom_range(6, 1));
            hv = 10'($urandom_range(5, 1));
         end
      endcase
      stop_sending();
      write_csr(s23x_pkg::CSR_SCALE, 10'($urandom_range(3)));
      write_csr(s23x_pkg::CSR_WIDTH, wv);
      write_csr(s23x_pkg::CSR_HEIGHT, hv);
      @(negedge clock);
      w = clamp_dim(wv, s23x_pkg::MAX_WIDTH);
      h = clamp_dim(hv, s23x_pkg::MAX_HEIGHT);
      total = w * h + w + 1;
      // occasionally a truncated frame, or one running into the next frame
      cut = total;
      if ($urandom_range(9) == 0) cut = $urandom_range(total);
      else if ($urandom_range(9) == 0) cut = total + $urandom_range(w * 2);
      // large geometries are only started
      if (cut > 64) cut = $urandom_range(64, 16);
      for (int k = 0; k < cut; k++) begin
         bit in_area;
         logic m;
         in_area = (k % total) < w * h;
         m = in_area ? MODE_PIXEL : MODE_DRAIN;
         if ($urandom_range(19) == 0) m = ~m;
         send_item(m, pick_pixel(), 1'b0, 32'd0);
         random_items++;
      end
   endtask

   row_type directed [] = '{
      '{ROW_ITEM, MODE_PIXEL,           32'hFFFF_FFFF, 1'b1},
      '{ROW_ITEM, MODE_DRAIN,           32'h0,         1'b1},
      '{ROW_ITEM, MODE_PIXEL,           32'hFFFF_FFFF, 1'b1},
      '{ROW_CSR,  s23x_pkg::CSR_SCALE,  32'd3,         1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'h0000_0000, 1'b1},
      '{ROW_ITEM, MODE_DRAIN,           32'h0,         1'b1},
      '{ROW_ITEM, MODE_DRAIN,           32'h0,         1'b1},
      '{ROW_CSR,  CSR_UNUSED,           32'h3FF,       1'b0},
      '{ROW_CSR,  s23x_pkg::CSR_SCALE,  32'd2,         1'b0},
      '{ROW_CSR,  s23x_pkg::CSR_WIDTH,  32'd3,         1'b0},
      '{ROW_CSR,  s23x_pkg::CSR_HEIGHT, 32'd3,         1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'hAAAA_AAAA, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'h5555_5555, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'hAAAA_AAAA, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'h5555_5555, 1'b0},
      '{ROW_ITEM, MODE_DRAIN,           32'hDEAD_BEEF, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'h5555_5555, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'hAAAA_AAAA, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'h5555_5555, 1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'hAAAA_AAAA, 1'b0},
      '{ROW_ITEM, MODE_DRAIN,           32'h0,         1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'hFFFF_FFFF, 1'b0},
      '{ROW_ITEM, MODE_DRAIN,           32'h0,         1'b0},
      '{ROW_ITEM, MODE_DRAIN,           32'h0,         1'b0},
      '{ROW_ITEM, MODE_PIXEL,           32'h1111_1111, 1'b0}
   };

   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected transfer: pixel %h col %0d row %0d", rsp_ch.data.out_pixel,
                   rsp_ch.data.out_column, rsp_ch.data.out_row);
            errors++;
         end else begin
            rsp_type e;
            e = pending_blocks.pop_front();
            if (rsp_ch.data.out_pixel !== e.out_pixel) begin
               $error("out_pixel expected %h actual %h", e.out_pixel, rsp_ch.data.out_pixel);
               errors++;
            end
            if (rsp_ch.data.out_column !== e.out_column) begin
               $error("out_column expected %0d actual %0d", e.out_column,
                      rsp_ch.data.out_column);
               errors++;
            end
            if (rsp_ch.data.out_row !== e.out_row) begin
               $error("out_row expected %0d actual %0d", e.out_row, rsp_ch.data.out_row);
               errors++;
            end
            if (rsp_ch.data.block_last !== e.block_last) begin
               $error("block_last expected %0b actual %0b", e.block_last,
                      rsp_ch.data.block_last);
               errors++;
            end
            if (rsp_ch.data.frame_last !== e.frame_last) begin
               $error("frame_last expected %0b actual %0b", e.frame_last,
                      rsp_ch.data.frame_last);
               errors++;
            end
         end
      end
   end

   initial begin
      int unsigned wait_cycles;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b1;
      scale_reg = 2'd2;
      width_reg = 10'd1;
      height_reg = 10'd1;
      in_x = 0;
      in_y = 0;
      for (int k = 0; k < s23x_pkg::MAX_WIDTH; k++) begin
         above_line[k] = '0;
         current_line[k] = '0;
      end
      for (int k = 0; k < 9; k++) win[k] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k]) begin
         if (directed[k].kind == ROW_CSR) begin
            stop_sending();
            write_csr(directed[k].sel, directed[k].value[9:0]);
         end else begin
            send_item(directed[k].sel[0], directed[k].value, directed[k].typed,
                      directed[k].value);
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         while (random_items < 40 * (phase + 1)) random_frame();
      end
      stop_sending();

      wait_cycles = 0;
      while (pending_blocks.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (errors == 0 && pending_blocks.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending_blocks.size() != 0)
            $error("%0d expected transfers never arrived", pending_blocks.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### scale2x_scale3x_upscaler_core.f
design/s23x_pkg.sv
design/s23x_if.sv
design/s23x_ram.sv
design/s23x_front.sv
design/s23x_back.sv
design/scale2x_scale3x_upscaler_core.sv
bench/scale2x_scale3x_upscaler_core_tb.sv
